// ===== sv/acp_pkg.sv =====
// Shared constants, command codes and small angle helpers for the angle cue lead predictor.
package acp_pkg;

  // Command codes carried on in_cmd.
  typedef enum logic [1:0] {
    CMD_UPDATE  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Angle units are 1/128 degree.
  localparam int HALF_TURN    = 23040;
  localparam int FULL_TURN    = 46080;
  localparam int QUARTER_TURN = 11520;
  localparam int US_PER_S     = 1000000;
  localparam logic [31:0] RATE_MAX = 32'h7FFF_FFFF;

  // Datapath widths of the serial units.
  localparam int NUM_W  = 40;  // product magnitude fed to the divider
  localparam int DEN_W  = 24;  // dt_us width
  localparam int MOD_W  = 42;  // magnitude fed to the angle reduction unit
  localparam int MOD_RW = 16;  // remainder width, holds values below FULL_TURN
  localparam int ID_W   = 64;
  localparam int AZ_W   = 16;
  localparam int EL_W   = 15;

  // Wrap a small azimuth (well inside two turns) into [-180, 180).
  function automatic logic signed [AZ_W-1:0] wrap_small(input logic signed [18:0] x);
    logic signed [19:0] y;
    y = 20'(x) + 20'sd23040;
    if (y < 0) y = y + 20'sd46080;
    if (y < 0) y = y + 20'sd46080;
    if (y >= 20'sd46080) y = y - 20'sd46080;
    if (y >= 20'sd46080) y = y - 20'sd46080;
    return AZ_W'(y - 20'sd23040);
  endfunction

  // Clamp an elevation to +/- 90 degrees.
  function automatic logic signed [EL_W-1:0] clamp_el(input logic signed [MOD_W-1:0] x);
    logic signed [MOD_W-1:0] r;
    r = x;
    if (x > MOD_W'(QUARTER_TURN)) r = MOD_W'(QUARTER_TURN);
    if (x < -MOD_W'(QUARTER_TURN)) r = -MOD_W'(QUARTER_TURN);
    return EL_W'(r);
  endfunction

endpackage

// ===== sv/acp_ram.sv =====
// Generic single-port-write, registered-read RAM.
module acp_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
  ) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
  );

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/acp_div.sv =====
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
module acp_div
  import acp_pkg::*;
  (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
  );

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  // One restoring step: shift in the next numerator bit and try the divisor.
  always_comb begin
    trial   = {rem_r, q_r[NUM_W-1]};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
    q_nxt   = {q_r[NUM_W-2:0], ge};
  end

  // Step counter and control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift registers for the numerator/quotient and the partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== sv/acp_mod.sv =====
// Bit-serial reduction of an unsigned magnitude modulo one full turn.
module acp_mod
  import acp_pkg::*;
  (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MOD_W-1:0]  val,
    output logic              done,
    output logic [MOD_RW-1:0] rem
  );

  localparam int CW = $clog2(MOD_W + 1);

  logic [MOD_W-1:0]  v_r;
  logic [MOD_RW-1:0] rem_r, rem_nxt;
  logic [CW-1:0]     cnt_r;
  logic              run_r;
  logic              done_r;
  logic [MOD_RW:0]   trial;

  // The remainder stays below one turn, so one compare and subtract suffices.
  always_comb begin
    trial   = {rem_r, v_r[MOD_W-1]};
    rem_nxt = (trial >= (MOD_RW + 1)'(FULL_TURN))
              ? MOD_RW'(trial - (MOD_RW + 1)'(FULL_TURN)) : MOD_RW'(trial);
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MOD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Input shift register and remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= val;
      rem_r <= '0;
    end else if (run_r) begin
      v_r   <= {v_r[MOD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== sv/angle_cue_lead_predictor_core.sv =====
// Top level of the angle cue lead predictor: target table, sequencer and lead arithmetic.
//
// Usage: an item is taken on a rising edge with start high and busy low. Update
// (cmd 0) yields one result beat, strobed by out_valid for exactly one cycle;
// release (cmd 1), clear (cmd 2) and cmd 3 yield none. The receiver cannot stall,
// so the result is simply presented for that one cycle.
// The target table sits in a RAM of MAX_TARGETS entries with a valid flag per entry
// in flip-flops. Each release or update scans the table one entry per cycle.
// With prediction an update runs two multiply and divide passes through two
// bit-serial dividers (azimuth and elevation lanes) and one serial reduction of the
// lead azimuth.
// busy is high while an item is in work; the result strobe appears in the first
// cycle that busy is low again, and a new item may be taken in that same cycle.
// Configuration: cfg_ready is always high; the user must write cfg_cue_latency_us
// only while the block is idle, which the block does not enforce. Reset (rst_n low,
// synchronous) empties the table, sets the latency to 100000 us and leaves the block idle.
module angle_cue_lead_predictor_core
  import acp_pkg::*;
  #(
    parameter int MAX_TARGETS = 16
  ) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              in_cmd,
    input  logic [63:0]             in_target_id,
    input  logic signed [16:0]      in_meas_azimuth,
    input  logic signed [15:0]      in_meas_elevation,
    input  logic [23:0]             in_dt_us,
    output logic                    out_valid,
    output logic signed [15:0]      out_cmd_azimuth,
    output logic signed [14:0]      out_cmd_elevation,
    output logic signed [31:0]      out_rate_azimuth,
    output logic signed [31:0]      out_rate_elevation,
    output logic                    out_used_prediction,
    output logic                    out_table_full,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [23:0]             cfg_cue_latency_us
  );

  localparam int IW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CW   = $clog2(MAX_TARGETS + 1);
  localparam int ENT_W = ID_W + AZ_W + EL_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_DIVGO  = 8'b0001_0000,
    S_DIVW   = 8'b0010_0000,
    S_MODGO  = 8'b0100_0000,
    S_MODW   = 8'b1000_0000
  } state_t;

  state_t state_r;

  // Captured item and configuration.
  logic [1:0]              cmd_r;
  logic [ID_W-1:0]         id_r;
  logic signed [16:0]      maz_r;
  logic signed [15:0]      mel_r;
  logic [DEN_W-1:0]        dt_r;
  logic [23:0]             lat_r;

  // Table state.
  logic [MAX_TARGETS-1:0]  valid_r;
  logic [CW-1:0]           cnt_r;
  logic                    chk_v_r;
  logic [IW-1:0]           chk_idx_r;
  logic                    hit_r, free_r;
  logic [IW-1:0]           hit_idx_r, free_idx_r;
  logic signed [AZ_W-1:0]  saz_r;
  logic signed [EL_W-1:0]  sel_r;

  // Arithmetic lanes.
  logic                    phase_r;
  logic                    neg_az_r, neg_el_r;
  logic [15:0]             mag_az_r;
  logic [16:0]             mag_el_r;
  logic [NUM_W-1:0]        prod_az_r, prod_el_r;
  logic                    yneg_r;
  logic [MOD_W-1:0]        ymag_r;

  // Result registers.
  logic                    out_valid_r;
  logic signed [AZ_W-1:0]  caz_r;
  logic signed [EL_W-1:0]  cel_r;
  logic signed [31:0]      raz_r, rel_r;
  logic                    used_r, full_r;

  // RAM signals.
  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [ENT_W-1:0]        ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [ENT_W-1:0]        ram_rdata;
  logic [ID_W-1:0]         rd_id;
  logic signed [AZ_W-1:0]  rd_az;
  logic signed [EL_W-1:0]  rd_el;

  // Serial units.
  logic                    div_start, div_done_az, div_done_el;
  logic [NUM_W-1:0]        quo_az, quo_el;
  logic                    mod_start, mod_done;
  logic [MOD_RW-1:0]       mod_rem;

  // Combinational helpers.
  logic signed [AZ_W-1:0]  caz0;
  logic signed [EL_W-1:0]  cel0;
  logic signed [AZ_W-1:0]  daz;
  logic signed [16:0]      del;
  logic                    pred;
  logic [23:0]             factor;
  logic signed [NUM_W:0]   qs_az, qs_el;
  logic signed [MOD_W-1:0] x_az, y_az, x_el;
  logic [31:0]             rmag_az, rmag_el;
  logic [MOD_RW-1:0]       wrap_pos;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Table RAM: id, wrapped azimuth and clamped elevation per entry.
  acp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TARGETS), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_id = ram_rdata[ENT_W-1 -: ID_W];
  assign rd_az = ram_rdata[EL_W +: AZ_W];
  assign rd_el = ram_rdata[EL_W-1:0];
  assign ram_raddr = cnt_r[IW-1:0];
  assign ram_we    = (state_r == S_DECIDE) && (cmd_r == CMD_UPDATE) && (hit_r || free_r);
  assign ram_waddr = hit_r ? hit_idx_r : free_idx_r;
  assign ram_wdata = {id_r, caz0, cel0};

  // Azimuth and elevation lanes of the divider.
  acp_div u_div_az (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .num (prod_az_r), .den (dt_r), .done (div_done_az), .quo (quo_az)
  );

  acp_div u_div_el (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .num (prod_el_r), .den (dt_r), .done (div_done_el), .quo (quo_el)
  );

  // Final wrap of the lead azimuth.
  acp_mod u_mod (
    .clk (clk), .rst_n (rst_n), .start (mod_start),
    .val (ymag_r), .done (mod_done), .rem (mod_rem)
  );

  assign div_start = (state_r == S_DIVGO);
  assign mod_start = (state_r == S_MODGO);

  // Plain angles, deltas and the signed quotients.
  always_comb begin
    caz0   = wrap_small(19'(maz_r));
    cel0   = clamp_el(MOD_W'(mel_r));
    daz    = wrap_small(19'(maz_r) - 19'(saz_r));
    del    = 17'(mel_r) - 17'(sel_r);
    pred   = hit_r && (dt_r != '0) && (lat_r != '0);
    factor = phase_r ? lat_r : 24'(US_PER_S);
    qs_az  = neg_az_r ? -$signed({1'b0, quo_az}) : $signed({1'b0, quo_az});
    qs_el  = neg_el_r ? -$signed({1'b0, quo_el}) : $signed({1'b0, quo_el});
    x_az   = MOD_W'(maz_r) + MOD_W'(qs_az);
    y_az   = x_az + MOD_W'(HALF_TURN);
    x_el   = MOD_W'(mel_r) + MOD_W'(qs_el);
    rmag_az = (quo_az > NUM_W'(RATE_MAX)) ? RATE_MAX : quo_az[31:0];
    rmag_el = (quo_el > NUM_W'(RATE_MAX)) ? RATE_MAX : quo_el[31:0];
    wrap_pos = (yneg_r && (mod_rem != '0)) ? MOD_RW'(FULL_TURN) - mod_rem
             : (yneg_r ? '0 : mod_rem);
  end

  // Control sequencer and table flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      lat_r       <= 24'd100000;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        lat_r <= cfg_cue_latency_us;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cnt_r   <= '0;
            chk_v_r <= 1'b0;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            phase_r <= 1'b0;
            if (in_cmd == CMD_CLEAR) begin
              valid_r <= '0;
            end else if (in_cmd == CMD_UPDATE || in_cmd == CMD_RELEASE) begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // One entry read per cycle; the compare uses the previous cycle's read.
          chk_v_r   <= (cnt_r < CW'(MAX_TARGETS));
          chk_idx_r <= cnt_r[IW-1:0];
          if (cnt_r < CW'(MAX_TARGETS)) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (chk_v_r) begin
            if (valid_r[chk_idx_r]) begin
              if (!hit_r && rd_id == id_r) begin
                hit_r     <= 1'b1;
                hit_idx_r <= chk_idx_r;
                saz_r     <= rd_az;
                sel_r     <= rd_el;
              end
            end else if (!free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= chk_idx_r;
            end
          end
          if (cnt_r == CW'(MAX_TARGETS) && !chk_v_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cmd_r == CMD_RELEASE) begin
            if (hit_r) begin
              valid_r[hit_idx_r] <= 1'b0;
            end
            state_r <= S_IDLE;
          end else begin
            if (hit_r) begin
              valid_r[hit_idx_r] <= 1'b1;
            end else if (free_r) begin
              valid_r[free_idx_r] <= 1'b1;
            end
            if (pred) begin
              state_r <= S_MUL;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        S_MUL: begin
          state_r <= S_DIVGO;
        end
        S_DIVGO: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done_az && div_done_el) begin
            if (!phase_r) begin
              phase_r <= 1'b1;
              state_r <= S_MUL;
            end else begin
              state_r <= S_MODGO;
            end
          end
        end
        S_MODGO: begin
          state_r <= S_MODW;
        end
        S_MODW: begin
          if (mod_done) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: captured item, lane operands and result fields.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_cmd;
      id_r  <= in_target_id;
      maz_r <= in_meas_azimuth;
      mel_r <= in_meas_elevation;
      dt_r  <= in_dt_us;
    end
    case (state_r)
      S_DECIDE: begin
        neg_az_r <= daz[AZ_W-1];
        neg_el_r <= del[16];
        mag_az_r <= daz[AZ_W-1] ? 16'(-daz) : 16'(daz);
        mag_el_r <= del[16] ? 17'(-del) : 17'(del);
        caz_r    <= caz0;
        cel_r    <= cel0;
        raz_r    <= '0;
        rel_r    <= '0;
        used_r   <= pred;
        full_r   <= !hit_r && !free_r;
      end
      S_MUL: begin
        prod_az_r <= NUM_W'(mag_az_r) * NUM_W'(factor);
        prod_el_r <= NUM_W'(mag_el_r) * NUM_W'(factor);
      end
      S_DIVW: begin
        if (div_done_az && div_done_el) begin
          if (!phase_r) begin
            raz_r <= neg_az_r ? -$signed(rmag_az) : $signed(rmag_az);
            rel_r <= neg_el_r ? -$signed(rmag_el) : $signed(rmag_el);
          end else begin
            yneg_r <= y_az[MOD_W-1];
            ymag_r <= y_az[MOD_W-1] ? MOD_W'(-y_az) : MOD_W'(y_az);
            cel_r  <= clamp_el(x_el);
          end
        end
      end
      S_MODW: begin
        if (mod_done) begin
          caz_r <= AZ_W'($signed({1'b0, wrap_pos}) - 17'sd23040);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_cmd_azimuth     = caz_r;
  assign out_cmd_elevation   = cel_r;
  assign out_rate_azimuth    = raz_r;
  assign out_rate_elevation  = rel_r;
  assign out_used_prediction = used_r;
  assign out_table_full      = full_r;

endmodule
